// ===== design/bru_pkg.sv =====
// Shared types, constants and helpers for the bilinear resize unit.
// No dependencies; bru_front, bru_back, the top level and the testbench import this package.
package bru_pkg;

  // Default storage geometry, handed down as top level parameters.
  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 256;
  localparam int ChannelsDef  = 3;

  // Fixed field widths.
  localparam int SizeW  = 9;   // size registers
  localparam int CoordW = 8;   // request and write coordinates
  localparam int SmpW   = 8;   // sample width
  localparam int ChanW  = 2;

  // Coordinate mapping: numerator and quotient widths of the divider.
  localparam int NumW      = 34;
  localparam int FracBits  = 16;
  localparam int PosOffset = 32768 - 128;   // half unit minus rounding bias

  // Queue between the front and the back.
  localparam int FifoDepth = 4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_TGT_WIDTH  = 2'd2,
    REG_TGT_HEIGHT = 2'd3
  } reg_idx_e;

  // What the back must do with an item.
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_ERROR = 2'd2
  } item_kind_e;

  typedef struct packed {
    logic              opcode;
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row_index;
    logic [ChanW-1:0]  chan;
    logic [SmpW-1:0]   sample_in;
  } in_word_t;

  typedef struct packed {
    logic [SmpW-1:0] sample_out;
    logic            status;
  } out_word_t;

  // Effective sizes, with zero read as one and the source clamped.
  typedef struct packed {
    logic [SizeW-1:0] src_w;
    logic [SizeW-1:0] src_h;
    logic [SizeW-1:0] tgt_w;
    logic [SizeW-1:0] tgt_h;
  } cfg_t;

  typedef struct packed {
    item_kind_e        kind;
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row_index;
    logic [ChanW-1:0]  chan;
    logic [SmpW-1:0]   sample;
  } item_t;

endpackage

// ===== design/bru_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bru_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bru_front.sv =====
// Front of the resize unit: takes input words, classifies them and queues them.
// Depends on bru_pkg.
module bru_front import bru_pkg::*; #(
  parameter int Channels = ChannelsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_word_i,
  output logic     head_valid_o,
  output item_t    head_item_o,
  input  logic     pop_i
);

  localparam int PtrW = $clog2(FifoDepth);

  item_t            fifo_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]    count_q, count_d;
  logic             push;
  logic             chan_ok;
  item_t            item;

  // Classify the incoming word against the current sizes.
  always_comb begin
    chan_ok = int'(in_word_i.chan) < Channels;
    item.column    = in_word_i.column;
    item.row_index = in_word_i.row_index;
    item.chan      = in_word_i.chan;
    item.sample    = in_word_i.sample_in;
    if (in_word_i.opcode == OP_WRITE) begin
      if ({1'b0, in_word_i.column} < cfg_i.src_w &&
          {1'b0, in_word_i.row_index} < cfg_i.src_h && chan_ok) begin
        item.kind = KIND_WRITE;
      end else begin
        item.kind = KIND_ERROR;
      end
    end else begin
      if ({1'b0, in_word_i.column} < cfg_i.tgt_w &&
          {1'b0, in_word_i.row_index} < cfg_i.tgt_h && chan_ok) begin
        item.kind = KIND_READ;
      end else begin
        item.kind = KIND_ERROR;
      end
    end
  end

  assign in_stall_o = (count_q == (PtrW+1)'(FifoDepth));
  assign push       = in_valid_i && !in_stall_o;

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (PtrW+1)'(push) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

  assign head_valid_o = (count_q != '0);
  assign head_item_o  = fifo_q[rd_ptr_q];

endmodule

// ===== design/bru_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; the denominator must stay constant while words pass.
module bru_div #(
  parameter int NumBits = 34,
  parameter int DenBits = 9
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic [NumBits-1:0] quo_o
);

  // Each stage holds the partial remainder and a word that shifts numerator
  // bits out at the top while quotient bits enter at the bottom.
  logic [DenBits-1:0] rem_q [NumBits];
  logic [NumBits-1:0] nq_q  [NumBits];

  for (genvar s = 0; s < NumBits; s++) begin : g_stage
    logic [DenBits-1:0] rem_in;
    logic [NumBits-1:0] nq_in;
    logic [DenBits:0]   trial;
    logic               fits;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign nq_in  = nq_q[s-1];
    end

    assign trial = {rem_in, nq_in[NumBits-1]};
    assign fits  = trial >= {1'b0, den_i};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= fits ? DenBits'(trial - {1'b0, den_i}) : DenBits'(trial);
        nq_q[s]  <= {nq_in[NumBits-2:0], fits};
      end
    end
  end

  assign quo_o = nq_q[NumBits-1];

endmodule

// ===== design/bru_back.sv =====
// Back of the resize unit: coordinate mapping, banked source store and blending.
// Depends on bru_pkg, bru_div and bru_ram.
module bru_back import bru_pkg::*; #(
  parameter int MaxWidth  = MaxWidthDef,
  parameter int MaxHeight = MaxHeightDef,
  parameter int Channels  = ChannelsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      head_valid_i,
  input  item_t     head_item_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int XW       = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int YW       = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int HalfW    = (MaxWidth + 1) / 2;
  localparam int HalfH    = (MaxHeight + 1) / 2;
  localparam int BankDep  = HalfW * HalfH * Channels;
  localparam int BankAw   = (BankDep > 1) ? $clog2(BankDep) : 1;
  localparam int ProdW    = CoordW + FracBits + SizeW;

  // Blend step: ((a << 8) + (b - a) * w + 128) mod 65536 >> 8.
  function automatic logic [SmpW-1:0] lerp(input logic [SmpW-1:0] a,
                                           input logic [SmpW-1:0] b,
                                           input logic [SmpW-1:0] w);
    logic [15:0] diff;
    logic [15:0] delta;
    logic [15:0] sum;
    diff  = {8'b0, b} - {8'b0, a};
    delta = 16'(diff * {8'b0, w});
    sum   = {a, 8'b0} + delta + 16'd128;
    return sum[15:8];
  endfunction

  logic adv;

  // The whole back moves together whenever the output register can take a word.
  assign adv   = !out_valid_o || !out_stall_i;
  assign pop_o = adv && head_valid_i;

  // Stage 1: scaled numerators.
  logic             m_valid_q;
  item_t            m_item_q;
  logic [ProdW-1:0] m_prod_x_q, m_prod_y_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_item_q   <= head_item_i;
      m_prod_x_q <= ProdW'({head_item_i.column, 16'h8000}) * ProdW'(cfg_i.src_w);
      m_prod_y_q <= ProdW'({head_item_i.row_index, 16'h8000}) * ProdW'(cfg_i.src_h);
    end
  end

  // Divider pipelines for both axes, with the item riding alongside.
  logic [NumW-1:0] num_x, num_y, quo_x, quo_y;
  logic            d_valid_q [NumW];
  item_t           d_item_q  [NumW];

  assign num_x = NumW'(m_prod_x_q) + NumW'(cfg_i.tgt_w >> 1);
  assign num_y = NumW'(m_prod_y_q) + NumW'(cfg_i.tgt_h >> 1);

  bru_div #(.NumBits(NumW), .DenBits(SizeW)) u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_x),
    .den_i (cfg_i.tgt_w),
    .quo_o (quo_x)
  );

  bru_div #(.NumBits(NumW), .DenBits(SizeW)) u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_y),
    .den_i (cfg_i.tgt_h),
    .quo_o (quo_y)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_item_q[0] <= m_item_q;
      for (int s = 1; s < NumW; s++) begin
        d_item_q[s] <= d_item_q[s-1];
      end
    end
  end

  // Map a quotient to a clamped index pair and an 8-bit weight.
  logic [SizeW-1:0] map_i0_x, map_i1_x, map_i0_y, map_i1_y;
  logic [SmpW-1:0]  map_w_x, map_w_y;

  always_comb begin
    logic [NumW-1:0] px, py;
    int              ipx, ipy, smx, smy;
    px  = quo_x - NumW'(PosOffset);
    py  = quo_y - NumW'(PosOffset);
    smx = int'(cfg_i.src_w) - 1;
    smy = int'(cfg_i.src_h) - 1;
    ipx = int'(px[NumW-1:FracBits]);
    ipy = int'(py[NumW-1:FracBits]);
    if (quo_x < NumW'(PosOffset)) begin
      map_i0_x = '0;
      map_w_x  = '0;
    end else begin
      map_i0_x = (ipx > smx) ? SizeW'(smx) : SizeW'(ipx);
      map_w_x  = px[FracBits-1:FracBits-8];
    end
    if (quo_y < NumW'(PosOffset)) begin
      map_i0_y = '0;
      map_w_y  = '0;
    end else begin
      map_i0_y = (ipy > smy) ? SizeW'(smy) : SizeW'(ipy);
      map_w_y  = py[FracBits-1:FracBits-8];
    end
    map_i1_x = (int'(map_i0_x) + 1 > smx) ? SizeW'(smx) : map_i0_x + 1'b1;
    map_i1_y = (int'(map_i0_y) + 1 > smy) ? SizeW'(smy) : map_i0_y + 1'b1;
  end

  // Stage: mapped coordinates; writes use their own column and row.
  logic            p_valid_q;
  item_t           p_item_q;
  logic [XW-1:0]   p_x0_q, p_x1_q;
  logic [YW-1:0]   p_y0_q, p_y1_q;
  logic [SmpW-1:0] p_wx_q, p_wy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_item_q <= d_item_q[NumW-1];
      p_wx_q   <= map_w_x;
      p_wy_q   <= map_w_y;
      if (d_item_q[NumW-1].kind == KIND_WRITE) begin
        p_x0_q <= XW'(d_item_q[NumW-1].column);
        p_x1_q <= XW'(d_item_q[NumW-1].column);
        p_y0_q <= YW'(d_item_q[NumW-1].row_index);
        p_y1_q <= YW'(d_item_q[NumW-1].row_index);
      end else begin
        p_x0_q <= XW'(map_i0_x);
        p_x1_q <= XW'(map_i1_x);
        p_y0_q <= YW'(map_i0_y);
        p_y1_q <= YW'(map_i1_y);
      end
    end
  end

  // Stage: bank addresses. Bank {y parity, x parity} holds every second
  // column and row, so the four neighbors always fall in distinct banks
  // unless an index was clamped onto its partner.
  logic              a_valid_q;
  item_t             a_item_q;
  logic [BankAw-1:0] a_addr_q [4];
  logic [3:0]        a_we_q;
  logic              a_x0p_q, a_x1p_q, a_y0p_q, a_y1p_q;
  logic [SmpW-1:0]   a_wx_q, a_wy_q;

  for (genvar b = 0; b < 4; b++) begin : g_addr
    localparam logic [1:0] BankId = 2'(b);
    logic [XW-1:0] xsel;
    logic [YW-1:0] ysel;
    assign xsel = (p_x0_q[0] == BankId[0]) ? p_x0_q : p_x1_q;
    assign ysel = (p_y0_q[0] == BankId[1]) ? p_y0_q : p_y1_q;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        a_addr_q[b] <= BankAw'((int'(ysel >> 1) * HalfW + int'(xsel >> 1)) * Channels
                               + int'(p_item_q.chan));
        a_we_q[b]   <= (p_item_q.kind == KIND_WRITE) &&
                       (p_x0_q[0] == BankId[0]) && (p_y0_q[0] == BankId[1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_item_q <= p_item_q;
      a_x0p_q  <= p_x0_q[0];
      a_x1p_q  <= p_x1_q[0];
      a_y0p_q  <= p_y0_q[0];
      a_y1p_q  <= p_y1_q[0];
      a_wx_q   <= p_wx_q;
      a_wy_q   <= p_wy_q;
    end
  end

  // Source store in four banks.
  logic [SmpW-1:0] rdata [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bru_ram #(.Width(SmpW), .Depth(BankDep), .AddrW(BankAw)) u_bank (
      .clk_i   (clk_i),
      .we_i    (adv && a_valid_q && a_we_q[b]),
      .waddr_i (a_addr_q[b]),
      .wdata_i (a_item_q.sample),
      .re_i    (adv),
      .raddr_i (a_addr_q[b]),
      .rdata_o (rdata[b])
    );
  end

  // Stage: read data returns; side information follows it.
  logic            r_valid_q;
  item_t           r_item_q;
  logic            r_x0p_q, r_x1p_q, r_y0p_q, r_y1p_q;
  logic [SmpW-1:0] r_wx_q, r_wy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_item_q <= a_item_q;
      r_x0p_q  <= a_x0p_q;
      r_x1p_q  <= a_x1p_q;
      r_y0p_q  <= a_y0p_q;
      r_y1p_q  <= a_y1p_q;
      r_wx_q   <= a_wx_q;
      r_wy_q   <= a_wy_q;
    end
  end

  // Vertical blend of both columns.
  logic [SmpW-1:0] nb00, nb01, nb10, nb11;
  assign nb00 = rdata[{r_y0p_q, r_x0p_q}];
  assign nb01 = rdata[{r_y1p_q, r_x0p_q}];
  assign nb10 = rdata[{r_y0p_q, r_x1p_q}];
  assign nb11 = rdata[{r_y1p_q, r_x1p_q}];

  logic            v_valid_q;
  item_t           v_item_q;
  logic [SmpW-1:0] v_left_q, v_right_q, v_wx_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v_item_q  <= r_item_q;
      v_left_q  <= lerp(nb00, nb01, r_wy_q);
      v_right_q <= lerp(nb10, nb11, r_wy_q);
      v_wx_q    <= r_wx_q;
    end
  end

  // Horizontal blend into the output register.
  out_word_t out_d;
  logic      out_valid_q, out_valid_d;
  out_word_t out_q;

  always_comb begin
    out_d.sample_out = lerp(v_left_q, v_right_q, v_wx_q);
    out_d.status     = 1'b0;
    if (v_item_q.kind == KIND_ERROR) begin
      out_d.sample_out = '0;
      out_d.status     = 1'b1;
    end
    out_valid_d = v_valid_q && (v_item_q.kind != KIND_WRITE);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      for (int s = 0; s < NumW; s++) begin
        d_valid_q[s] <= 1'b0;
      end
      p_valid_q   <= 1'b0;
      a_valid_q   <= 1'b0;
      r_valid_q   <= 1'b0;
      v_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q    <= head_valid_i;
      d_valid_q[0] <= m_valid_q;
      for (int s = 1; s < NumW; s++) begin
        d_valid_q[s] <= d_valid_q[s-1];
      end
      p_valid_q   <= d_valid_q[NumW-1];
      a_valid_q   <= p_valid_q;
      r_valid_q   <= a_valid_q;
      v_valid_q   <= r_valid_q;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== design/bilinear_resize_u8_unit.sv =====
// Bilinear resize unit: top level with the configuration registers.
// Depends on bru_pkg, bru_front, bru_back (and through it bru_div, bru_ram).
//
// The unit holds a source image written word by word and returns one
// bilinearly interpolated destination sample per request word. It takes one
// word per clock and returns one result word per clock when the output side
// does not stall. An accepted word passes through the input queue, the
// coordinate products and the pipelined dividers that map each axis, then
// mapping, bank addressing, the registered store read and the vertical
// blend, after which its result sits in the output register. The store is
// split into four banks by column and row parity so the four neighbors are
// read at once. Writes go through the same pipeline, so a request always sees
// exactly the writes accepted before it. A successful write gives no result
// word; an out of range write or request gives a word with status set.
// Size registers may only be changed while no word is in flight.
module bilinear_resize_u8_unit import bru_pkg::*; #(
  parameter int MaxWidth  = MaxWidthDef,
  parameter int MaxHeight = MaxHeightDef,
  parameter int Channels  = ChannelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [SizeW-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
  logic             cfg_wr;
  reg_idx_e         reg_idx;
  cfg_t             cfg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SizeW'(1);
      src_h_q <= SizeW'(1);
      tgt_w_q <= SizeW'(1);
      tgt_h_q <= SizeW'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SRC_WIDTH:  src_w_q <= pwdata[SizeW-1:0];
        REG_SRC_HEIGHT: src_h_q <= pwdata[SizeW-1:0];
        REG_TGT_WIDTH:  tgt_w_q <= pwdata[SizeW-1:0];
        REG_TGT_HEIGHT: tgt_h_q <= pwdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_idx)
      REG_SRC_WIDTH:  prdata = 32'(src_w_q);
      REG_SRC_HEIGHT: prdata = 32'(src_h_q);
      REG_TGT_WIDTH:  prdata = 32'(tgt_w_q);
      REG_TGT_HEIGHT: prdata = 32'(tgt_h_q);
      default:        prdata = '0;
    endcase
  end

  // Effective sizes: zero acts as one, source sizes clamp to the store.
  always_comb begin
    cfg.src_w = (src_w_q == '0) ? SizeW'(1) : src_w_q;
    cfg.src_h = (src_h_q == '0) ? SizeW'(1) : src_h_q;
    cfg.tgt_w = (tgt_w_q == '0) ? SizeW'(1) : tgt_w_q;
    cfg.tgt_h = (tgt_h_q == '0) ? SizeW'(1) : tgt_h_q;
    if (int'(src_w_q) > MaxWidth) begin
      cfg.src_w = SizeW'(MaxWidth);
    end
    if (int'(src_h_q) > MaxHeight) begin
      cfg.src_h = SizeW'(MaxHeight);
    end
  end

  logic  head_valid;
  item_t head_item;
  logic  pop;

  bru_front #(.Channels(Channels)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .head_valid_o (head_valid),
    .head_item_o  (head_item),
    .pop_i        (pop)
  );

  bru_back #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight),
    .Channels  (Channels)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_item_i  (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for bilinear_resize_u8_unit: a scoreboard class predicts
// every result word, and plain tasks drive the word, result and APB ports.
// Depends on bru_pkg and the RTL of the unit only.
module tb;
  import bru_pkg::*;

  localparam int unsigned ImgSize  = MaxWidthDef * MaxHeightDef * ChannelsDef;
  localparam int unsigned CycLimit = 600000;
  localparam int unsigned Settle   = 60;

  // Predicts result words from the accepted words and the current sizes.
  class resize_scoreboard;
    byte unsigned src_img[ImgSize];
    logic [SizeW-1:0] size_reg[4];
    out_word_t expected_q[$];
    int unsigned mismatches;
    int unsigned n_stored, n_blended, n_flagged;

    function new();
      foreach (size_reg[i]) size_reg[i] = SizeW'(1);
      mismatches = 0;
      n_stored = 0;
      n_blended = 0;
      n_flagged = 0;
    endfunction

    // A zero register acts as one; larger values are capped.
    function int unsigned eff(int unsigned v, int unsigned cap);
      if (v == 0) return 1;
      if (v > cap) return cap;
      return v;
    endfunction

    function int unsigned src_w();
      return eff(32'(size_reg[REG_SRC_WIDTH]), MaxWidthDef);
    endfunction
    function int unsigned src_h();
      return eff(32'(size_reg[REG_SRC_HEIGHT]), MaxHeightDef);
    endfunction
    function int unsigned tgt_w();
      return eff(32'(size_reg[REG_TGT_WIDTH]), 65535);
    endfunction
    function int unsigned tgt_h();
      return eff(32'(size_reg[REG_TGT_HEIGHT]), 65535);
    endfunction

    // Maps a destination coordinate to two source indexes and a weight.
    function void map_axis(int unsigned d, int unsigned s, int unsigned t,
                           output int unsigned i0, output int unsigned i1,
                           output int unsigned w);
      logic [63:0] num;
      logic [63:0] p;
      logic [63:0] ip;
      num = ((64'(d) << 16) + 64'd32768) * 64'(s);
      p = (num + 64'(t / 2)) / 64'(t);
      p = p - 64'd32768 + 64'd128;
      if (p[63]) begin
        i0 = 0;
        w = 0;
      end else begin
        ip = p >> 16;
        i0 = (ip > 64'(s - 1)) ? s - 1 : 32'(ip);
        w = 32'(p[15:8]);
      end
      i1 = (i0 + 1 > s - 1) ? s - 1 : i0 + 1;
    endfunction

    function int unsigned blend(int unsigned a, int unsigned b, int unsigned w);
      logic [31:0] delta;
      logic [31:0] sum;
      delta = ((b - a) * w) & 32'hFFFF;
      sum = ((a << 8) + delta + 128) & 32'hFFFF;
      return 32'(sum[15:8]);
    endfunction

    function int unsigned pix(int unsigned x, int unsigned y, int unsigned c);
      return 32'(src_img[(y * MaxWidthDef + x) * ChannelsDef + c]);
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] val);
      size_reg[idx] = val[SizeW-1:0];
    endfunction

    // Notes an accepted word and queues the result it causes, if any.
    function void note_word(in_word_t w);
      int unsigned x0, x1, y0, y1, wx, wy, lft, rgt;
      out_word_t e;
      e.sample_out = '0;
      e.status = 1'b1;
      if (w.opcode == OP_WRITE) begin
        if (w.column < src_w() && w.row_index < src_h() && w.chan < ChannelsDef) begin
          src_img[(w.row_index * MaxWidthDef + w.column) * ChannelsDef + w.chan] =
            w.sample_in;
          n_stored++;
          return;
        end
        n_flagged++;
      end else if (w.column >= tgt_w() || w.row_index >= tgt_h() ||
                   w.chan >= ChannelsDef) begin
        n_flagged++;
      end else begin
        map_axis(32'(w.row_index), src_h(), tgt_h(), y0, y1, wy);
        map_axis(32'(w.column), src_w(), tgt_w(), x0, x1, wx);
        lft = blend(pix(x0, y0, 32'(w.chan)), pix(x0, y1, 32'(w.chan)), wy);
        rgt = blend(pix(x1, y0, 32'(w.chan)), pix(x1, y1, 32'(w.chan)), wy);
        e.sample_out = 8'(blend(lft, rgt, wx));
        e.status = 1'b0;
        n_blended++;
      end
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    // Compares a result word with the oldest expectation.
    task check_result(out_word_t got);
      out_word_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d/%0d with nothing expected",
                         got.sample_out, got.status));
        return;
      end
      e = expected_q.pop_front();
      if (got.sample_out !== e.sample_out)
        report($sformatf("sample_out %0d, expected %0d", got.sample_out, e.sample_out));
      if (got.status !== e.status)
        report($sformatf("status %0d, expected %0d", got.status, e.status));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_word_t    in_word_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_word_t   out_word_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  resize_scoreboard sb;
  bit written[ImgSize];
  bit idle_en;
  bit hold_req;
  int unsigned cycles;
  int unsigned words_sent;

  bilinear_resize_u8_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_word_o);
  end

  // Receiver stall: random bursts, plus one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall_i = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // Offers one word, waits for acceptance; called and returns at a falling edge.
  task automatic push_word(in_word_t w);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i = w;
    do @(posedge clk_i); while (in_stall_o);
    if (w.opcode == OP_WRITE && w.column < sb.src_w() && w.row_index < sb.src_h() &&
        w.chan < ChannelsDef)
      written[(w.row_index * MaxWidthDef + w.column) * ChannelsDef + w.chan] = 1'b1;
    sb.note_word(w);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic store_sample(int unsigned x, int unsigned y, int unsigned c,
                              logic [7:0] v);
    in_word_t w;
    w.opcode = OP_WRITE;
    w.column = 8'(x);
    w.row_index = 8'(y);
    w.chan = 2'(c);
    w.sample_in = v;
    push_word(w);
  endtask

  // Sends a word, first loading, for an in-range request, any of its four neighbors not yet written.
  task automatic request_sample(in_word_t w);
    int unsigned x0, x1, y0, y1, wx, wy;
    int unsigned xs[2];
    int unsigned ys[2];
    if (w.opcode == OP_READ && w.column < sb.tgt_w() && w.row_index < sb.tgt_h() &&
        w.chan < ChannelsDef) begin
      sb.map_axis(32'(w.row_index), sb.src_h(), sb.tgt_h(), y0, y1, wy);
      sb.map_axis(32'(w.column), sb.src_w(), sb.tgt_w(), x0, x1, wx);
      xs[0] = x0;
      xs[1] = x1;
      ys[0] = y0;
      ys[1] = y1;
      foreach (xs[i])
        foreach (ys[j])
          if (!written[(ys[j] * MaxWidthDef + xs[i]) * ChannelsDef + w.chan])
            store_sample(xs[i], ys[j], 32'(w.chan), 8'($urandom_range(0, 255)));
    end
    push_word(w);
  endtask

  // Waits until every expected word is back, then lets the pipeline empty.
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (Settle) @(negedge clk_i);
  endtask

  // APB write of one size register: setup cycle, then access cycle.
  task automatic write_reg(reg_idx_e idx, int unsigned val);
    logic [31:0] data;
    data = {($urandom_range(0, 1) ? 23'($urandom) : 23'd0), 9'(val)};
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = 4'(idx) << 2;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned tw,
                           int unsigned th);
    drain();
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_TGT_WIDTH, tw);
    write_reg(REG_TGT_HEIGHT, th);
  endtask

  function automatic in_word_t make_word(logic op, int unsigned x, int unsigned y,
                                         int unsigned c);
    in_word_t w;
    w.opcode = op;
    w.column = 8'(x);
    w.row_index = 8'(y);
    w.chan = 2'(c);
    w.sample_in = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic int unsigned pick_size(int unsigned hi);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return 256;
      3: return 511;
      default: return $urandom_range(1, hi);
    endcase
  endfunction

  // One random word of the current phase.
  task automatic random_word();
    in_word_t w;
    int unsigned r;
    int unsigned tw, th;
    r = $urandom_range(0, 99);
    tw = (sb.tgt_w() > 256) ? 256 : sb.tgt_w();
    th = (sb.tgt_h() > 256) ? 256 : sb.tgt_h();
    if (r < 45) begin
      request_sample(make_word(OP_READ, $urandom_range(0, tw - 1),
                               $urandom_range(0, th - 1), $urandom_range(0, 2)));
    end else if (r < 65) begin
      push_word(make_word(OP_WRITE, $urandom_range(0, sb.src_w() - 1),
                          $urandom_range(0, sb.src_h() - 1), $urandom_range(0, 2)));
    end else if (r < 85) begin
      // Out of range word: forced onto the invalid channel when the position fits.
      w = make_word(r < 75 ? OP_WRITE : OP_READ, $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 3));
      if (w.opcode == OP_WRITE && w.column < sb.src_w() && w.row_index < sb.src_h())
        w.chan = 2'd3;
      if (w.opcode == OP_READ && w.column < sb.tgt_w() && w.row_index < sb.tgt_h())
        w.chan = 2'd3;
      push_word(w);
    end else begin
      request_sample(make_word(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 3)));
    end
  endtask

  initial begin
    int unsigned phase;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    cycles = 0;
    words_sent = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset sizes, one-pixel image, extremes and error cases.
    store_sample(0, 0, 0, 8'd0);
    store_sample(0, 0, 1, 8'd255);
    store_sample(0, 0, 2, 8'h5A);
    push_word(make_word(OP_WRITE, 0, 0, 3));
    push_word(make_word(OP_WRITE, 255, 255, 0));
    push_word(make_word(OP_READ, 0, 0, 0));
    push_word(make_word(OP_READ, 0, 0, 1));
    push_word(make_word(OP_READ, 0, 0, 3));
    push_word(make_word(OP_READ, 1, 0, 2));
    push_word(make_word(OP_READ, 0, 255, 2));
    // Upscaling a 2x2 image: the corners hit the negative coordinate clamp and the upper index clamp.
    set_sizes(2, 2, 4, 4);
    store_sample(0, 0, 0, 8'd0);
    store_sample(1, 0, 0, 8'd255);
    store_sample(0, 1, 0, 8'd255);
    store_sample(1, 1, 0, 8'd0);
    push_word(make_word(OP_READ, 0, 0, 0));
    push_word(make_word(OP_READ, 3, 3, 0));
    push_word(make_word(OP_READ, 1, 2, 0));
    push_word(make_word(OP_READ, 2, 1, 0));
    push_word(make_word(OP_READ, 4, 0, 0));
    push_word(make_word(OP_WRITE, 2, 0, 1));

    // Random phases, extremes first, then random sizes.
    phase = 0;
    while (words_sent < 1900) begin
      case (phase)
        0: set_sizes(256, 256, 256, 256);
        1: set_sizes(511, 511, 511, 511);
        2: set_sizes(0, 0, 0, 0);
        3: set_sizes(256, 3, 7, 300);
        default: set_sizes(pick_size(16), pick_size(16), pick_size(40), pick_size(40));
      endcase
      if (phase == 4) hold_req = 1'b1;
      repeat (150) begin
        if (words_sent > 1650) idle_en = 1'b0;
        random_word();
      end
      phase++;
    end
    drain();

    $display("Covered %0d stored samples, %0d blended requests, %0d flagged words,",
             sb.n_stored, sb.n_blended, sb.n_flagged);
    $display("over %0d size settings including zero, 256 and 511.", phase + 2);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bru_pkg.sv
design/bru_ram.sv
design/bru_front.sv
design/bru_div.sv
design/bru_back.sv
design/bilinear_resize_u8_unit.sv
verif/tb.sv
